@@ sv/rtffg_pkg.sv @@
// ----------------------------------------------------------------------------
// rtffg_pkg
// Shared types and constants for the first-fit gap unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rtffg_pkg;
  localparam int REGIONS = 16;
  localparam int IDX_W = $clog2(REGIONS);
  // counts the sort phase: the table feed, then the chain settle
  localparam int CNT_W = $clog2(2 * REGIONS);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_STATS = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_POOL_BASE = 1'b0,
    CFG_POOL_TOP  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_SCAN,
    ST_DONE
  } state_t;

  // entry handed down the sorting chain; idx breaks ties on equal bases
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [31:0]      base;
    logic [31:0]      size;
  } ent_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;
endpackage
`default_nettype wire

@@ sv/rtffg_cell.sv @@
// ----------------------------------------------------------------------------
// rtffg_cell
// One slot of the insertion-sort chain. On insert, a slot keeps the entry
// ordered first by (base, table index) and registers the other one for its
// downstream neighbor. On shift, the slot takes its downstream neighbor's
// entry so the sorted list drains out of cell 0.
// ----------------------------------------------------------------------------
`default_nettype none
module rtffg_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rtffg_pkg::cell_ctl_t ctl,
  input  wire rtffg_pkg::ent_t   din,
  output rtffg_pkg::ent_t        dout,
  output rtffg_pkg::ent_t        held
);
  import rtffg_pkg::*;

  ent_t slot;
  ent_t pass;
  logic din_first;

  always_comb begin
    held = slot;
    dout = pass;
    din_first = (din.base < slot.base) ||
                ((din.base == slot.base) && (din.idx < slot.idx));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      slot.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (ctl.shift) begin
      slot <= din;
      pass.valid <= 1'b0;
    end else if (ctl.insert) begin
      if (!din.valid) begin
        pass <= din;
      end else if (!slot.valid) begin
        slot <= din;
        pass.valid <= 1'b0;
      end else if (din_first) begin
        slot <= din;
        pass <= slot;
      end else begin
        pass <= din;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/region_table_first_fit_gap_unit.sv @@
// ----------------------------------------------------------------------------
// region_table_first_fit_gap_unit
// First-fit gap search and free space statistics over a 16-entry region table.
// ----------------------------------------------------------------------------
// channel | signals                                              | direction
// command | start, busy, cmd, entry_*, request_size              | in; busy out
// result  | done, fit_found, fit_base, free_total, largest_gap   | out
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data            | in; cfg_ready out
// A write or unused code: the unit goes from idle to the done state, which registers done.
// Queries: the sort state feeds the table into the sort chain and lets it
// settle, the scan state shifts the sorted entries out of cell 0, and the
// done state registers the results and done; the next start can be taken
// at the edge that ends done. Reset clears the table used flags and the pool
// registers. Config is held off while busy. done is one cycle wide; the
// receiver cannot stall it.
`default_nettype none
module region_table_first_fit_gap_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  entry_index,
  input  wire logic        entry_used,
  input  wire logic [31:0] entry_base,
  input  wire logic [31:0] entry_size,
  input  wire logic [31:0] request_size,
  output logic             done,
  output logic             fit_found,
  output logic [31:0]      fit_base,
  output logic [31:0]      free_total,
  output logic [31:0]      largest_gap,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rtffg_pkg::*;

  logic [31:0] pool_base, pool_top;
  logic        reg_used [REGIONS];
  logic [31:0] reg_base [REGIONS];
  logic [31:0] reg_size [REGIONS];

  state_t      state, state_next;
  cmd_t        op;
  logic [31:0] need;
  logic [CNT_W-1:0] cnt;
  logic [31:0] gstart;
  logic        found;
  logic [31:0] fbase, ftotal, flarge;

  cell_ctl_t ctl;
  ent_t      chain [REGIONS+1];
  ent_t      held  [REGIONS];
  ent_t      feed;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_top  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POOL_BASE: pool_base <= cfg_data;
        CFG_POOL_TOP:  pool_top  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGIONS; i++) reg_used[i] <= 1'b0;
    end else if (start && !busy && cmd_t'(cmd) == CMD_WRITE) begin
      reg_used[entry_index] <= entry_used;
      reg_base[entry_index] <= entry_base;
      reg_size[entry_index] <= entry_size;
    end
  end

  // feed the table into the chain head, one entry per cycle, then let it settle
  always_comb begin
    feed = '0;
    if (state == ST_SORT && cnt < CNT_W'(REGIONS)) begin
      if (reg_used[cnt[IDX_W-1:0]] && (reg_base[cnt[IDX_W-1:0]] != '0)) begin
        feed.valid = 1'b1;
        feed.idx   = cnt[IDX_W-1:0];
        feed.base  = reg_base[cnt[IDX_W-1:0]];
        feed.size  = reg_size[cnt[IDX_W-1:0]];
      end
    end
  end

  assign chain[0] = feed;

  always_comb begin
    ctl.clear  = start && !busy;
    ctl.insert = (state == ST_SORT);
    ctl.shift  = (state == ST_SCAN);
  end

  // insert: entries move down the chain; scan: each cell takes its downstream
  // neighbor, so cell 0 presents the sorted list in order
  genvar g;
  generate
    for (g = 0; g < REGIONS; g++) begin : g_cell
      ent_t cin;
      if (g == REGIONS - 1) begin : g_last
        assign cin = ctl.shift ? ent_t'('0) : chain[g];
      end else begin : g_mid
        assign cin = ctl.shift ? held[g+1] : chain[g];
      end
      rtffg_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .din  (cin),
        .dout (chain[g+1]),
        .held (held[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = (cmd_t'(cmd) == CMD_ALLOC ||
                                        cmd_t'(cmd) == CMD_STATS) ? ST_SORT : ST_DONE;
      ST_SORT: if (cnt == CNT_W'(2 * REGIONS - 1)) state_next = ST_SCAN;
      ST_SCAN: if (cnt == CNT_W'(REGIONS - 1)) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [31:0] gap;
  logic [31:0] tail_gap;
  assign gap = held[0].base - gstart;
  assign tail_gap = pool_top - gstart;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (start) begin
            op     <= cmd_t'(cmd);
            need   <= (request_size + 32'd3) & ~32'd3;
            gstart <= pool_base;
            found  <= 1'b0;
            fbase  <= '0;
            ftotal <= '0;
            flarge <= '0;
          end
        end
        ST_SORT: cnt <= (cnt == CNT_W'(2 * REGIONS - 1)) ? '0 : cnt + 1'b1;
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (held[0].valid) begin
            if (!found) begin
              if (gap >= need) begin
                found <= 1'b1;
                fbase <= gstart;
              end
            end
            ftotal <= ftotal + gap;
            if (gap > flarge) flarge <= gap;
            if (!(found || gap >= need) || op == CMD_STATS) begin
              gstart <= held[0].base + held[0].size;
            end
          end
        end
        ST_DONE: begin
          done <= 1'b1;
          fit_found <= 1'b0;
          fit_base <= '0;
          free_total <= '0;
          largest_gap <= '0;
          if (op == CMD_ALLOC) begin
            if (found) begin
              fit_found <= 1'b1;
              fit_base  <= fbase;
            end else if (tail_gap >= need) begin
              fit_found <= 1'b1;
              fit_base  <= gstart;
            end
          end else if (op == CMD_STATS) begin
            free_total  <= ftotal + tail_gap;
            largest_gap <= (tail_gap > flarge) ? tail_gap : flarge;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
